### design/fir_pkg.sv
// Shared constants and helpers for the FIR filter unit.
`timescale 1ns / 1ps

package fir_pkg;

  localparam int NUM_TAPS = 11;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 6;
  localparam int TAP_W    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

  localparam logic [TAP_W-1:0]   TAP_LAST  = TAP_W'(NUM_TAPS - 1);
  localparam logic [INDEX_W:0]   TAP_LIMIT = (INDEX_W + 1)'(NUM_TAPS);

  localparam logic FUNC_COEF   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef logic [TAP_W-1:0]  tap_addr_t;
  typedef logic [DATA_W-1:0] word_t;

  function automatic tap_addr_t tap_inc(input tap_addr_t a);
    tap_inc = (a == TAP_LAST) ? '0 : tap_addr_t'(a + 1'b1);
  endfunction

  function automatic tap_addr_t tap_dec(input tap_addr_t a);
    tap_dec = (a == '0) ? TAP_LAST : tap_addr_t'(a - 1'b1);
  endfunction

endpackage

### design/fir_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/fir_filter_unit.sv
// Top level of the direct-form FIR filter unit.
//
// Input channel (in_valid / in_stall): one beat carries func, tap_index and
// value. func = FUNC_COEF stores value as tap tap_index (indexes past the
// last tap are dropped) and gives no result; the input stays open after it.
// func = FUNC_SAMPLE pushes value into the delay line and gives one result.
// Output channel (out_valid / out_stall): one beat carries filtered, the
// sum of tap[i] * sample[i] over all NUM_TAPS taps, wrapped to 32 bits.
// Taps and samples sit in two RAMs; the delay line is a circular buffer.
// One multiplier steps through the taps, one per cycle, and in_stall stays
// high from a sample's beat until its result is loaded into the output
// register; only then is the next item taken.
// A finished sum holds in the accumulator, with in_stall high, until the
// output register frees up.
// Reset starts a clearing pass that zeroes every entry of both RAMs;
// in_stall stays high during it.
`timescale 1ns / 1ps

module fir_filter_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [fir_pkg::INDEX_W-1:0]        tap_index,
  input  logic signed [fir_pkg::DATA_W-1:0]  value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fir_pkg::DATA_W-1:0]  filtered
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  logic [1:0]          state;
  fir_pkg::tap_addr_t  head;
  fir_pkg::tap_addr_t  rptr;
  fir_pkg::tap_addr_t  k;
  logic                rd_v;
  logic                rd_last;
  logic                mul_v;
  logic                mul_last;
  logic                res_ready;
  fir_pkg::word_t      prod;
  fir_pkg::word_t      acc;
  fir_pkg::word_t      coef_rdata;
  fir_pkg::word_t      dl_rdata;

  logic                accept;
  logic                coef_we;
  fir_pkg::tap_addr_t  coef_waddr;
  fir_pkg::word_t      coef_wdata;
  logic                dl_we;
  fir_pkg::tap_addr_t  dl_waddr;
  fir_pkg::word_t      dl_wdata;
  logic                out_free;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = tap_index[fir_pkg::TAP_W-1:0];
    coef_wdata = $unsigned(value);
    dl_we      = 1'b0;
    dl_waddr   = head;
    dl_wdata   = $unsigned(value);
    if (state == ST_CLEAR) begin
      coef_we    = 1'b1;
      coef_waddr = k;
      coef_wdata = '0;
      dl_we      = 1'b1;
      dl_waddr   = k;
      dl_wdata   = '0;
    end else if (accept) begin
      coef_we = (func == fir_pkg::FUNC_COEF) && ({1'b0, tap_index} < fir_pkg::TAP_LIMIT);
      dl_we   = (func == fir_pkg::FUNC_SAMPLE);
    end
  end

  fir_ram #(
    .WIDTH (fir_pkg::DATA_W),
    .DEPTH (fir_pkg::NUM_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (k),
    .rdata (coef_rdata)
  );

  fir_ram #(
    .WIDTH (fir_pkg::DATA_W),
    .DEPTH (fir_pkg::NUM_TAPS)
  ) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (rptr),
    .rdata (dl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      head      <= '0;
      rptr      <= '0;
      k         <= '0;
      rd_v      <= 1'b0;
      rd_last   <= 1'b0;
      mul_v     <= 1'b0;
      mul_last  <= 1'b0;
      res_ready <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v     <= (state == ST_RUN);
      rd_last  <= (state == ST_RUN) && (k == fir_pkg::TAP_LAST);
      mul_v    <= rd_v;
      mul_last <= rd_v && rd_last;
      if (mul_v && mul_last) begin
        res_ready <= 1'b1;
      end
      if ((state == ST_WAIT) && res_ready && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (k == fir_pkg::TAP_LAST) begin
            k     <= '0;
            state <= ST_IDLE;
          end else begin
            k <= fir_pkg::tap_inc(k);
          end
        end
        ST_IDLE: begin
          if (accept && (func == fir_pkg::FUNC_SAMPLE)) begin
            rptr  <= head;
            head  <= fir_pkg::tap_inc(head);
            k     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          rptr <= fir_pkg::tap_dec(rptr);
          if (k == fir_pkg::TAP_LAST) begin
            k     <= '0;
            state <= ST_WAIT;
          end else begin
            k <= fir_pkg::tap_inc(k);
          end
        end
        ST_WAIT: begin
          if (res_ready && out_free) begin
            res_ready <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      prod <= coef_rdata * dl_rdata;
    end
    if (accept && (func == fir_pkg::FUNC_SAMPLE)) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + prod;
    end
    if ((state == ST_WAIT) && res_ready && out_free) begin
      filtered <= $signed(acc);
    end
  end

endmodule

### design/fir_checker.sv
// Port-level assertions for the FIR filter unit, bound to the top level.
`timescale 1ns / 1ps

module fir_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               func,
  input logic [fir_pkg::INDEX_W-1:0]        tap_index,
  input logic signed [fir_pkg::DATA_W-1:0]  value,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [fir_pkg::DATA_W-1:0]  filtered
);

  logic in_beat;
  assign in_beat = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered))
    else $error("stalled output beat changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("output valid or input open right after reset");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat && (func == fir_pkg::FUNC_SAMPLE) |=> in_stall)
    else $error("input open right after a sample beat");

  a_coef_quick: assert property (@(posedge clk) disable iff (rst)
    in_beat && (func == fir_pkg::FUNC_COEF) |=> !in_stall && !$rose(out_valid))
    else $error("coefficient beat stalled input or made a result");

endmodule

bind fir_filter_unit fir_checker u_fir_checker (.*);

### test/tb_fir_filter_unit.sv
// Self-checking testbench for the FIR filter unit: directed table plus random beats.
`timescale 1ns / 1ps

module tb_fir_filter_unit;

  localparam int RANDOM_ITEMS = 1925;
  localparam int PHASES       = 4;
  localparam int DRAIN_LIMIT  = 20000;

  typedef struct packed {
    logic                         func;
    logic [fir_pkg::INDEX_W-1:0]  tap_index;
    fir_pkg::word_t               value;
    logic                         typed;
    fir_pkg::word_t               result;
  } fir_row_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic                               func = fir_pkg::FUNC_COEF;
  logic [fir_pkg::INDEX_W-1:0]        tap_index = '0;
  logic signed [fir_pkg::DATA_W-1:0]  value = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic signed [fir_pkg::DATA_W-1:0]  filtered;

  fir_pkg::word_t tap_coef [fir_pkg::NUM_TAPS];
  fir_pkg::word_t sample_hist [fir_pkg::NUM_TAPS];
  fir_pkg::word_t expected_filtered [$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int samples_sent = 0;
  int coef_writes = 0;
  int results_seen = 0;
  int errors = 0;

  fir_row_t directed [25] = '{
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
    '{fir_pkg::FUNC_SAMPLE, 6'd63, 32'h8000_0000, 1'b1, 32'h0000_0000},
    '{fir_pkg::FUNC_COEF,   6'd63, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{fir_pkg::FUNC_COEF,   6'd11, 32'h0000_0005, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'h0000_0001, 1'b1, 32'h0000_0000},
    '{fir_pkg::FUNC_COEF,   6'd0,  32'h0000_0001, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd42, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{fir_pkg::FUNC_COEF,   6'd0,  32'h0000_0000, 1'b0, 32'h0},
    '{fir_pkg::FUNC_COEF,   6'd10, 32'h0000_0001, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd21, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{fir_pkg::FUNC_COEF,   6'd5,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{fir_pkg::FUNC_COEF,   6'd6,  32'h8000_0000, 1'b0, 32'h0},
    '{fir_pkg::FUNC_COEF,   6'd1,  32'hFFFF_FFFF, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'h8000_0000, 1'b0, 32'h0},
    '{fir_pkg::FUNC_COEF,   6'd2,  32'h1234_5678, 1'b0, 32'h0},
    '{fir_pkg::FUNC_COEF,   6'd9,  32'hFFFF_FFFF, 1'b0, 32'h0},
    '{fir_pkg::FUNC_COEF,   6'd10, 32'h8000_0000, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'h8000_0000, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'hFFFF_FFFF, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'h0000_0000, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'h8000_0000, 1'b0, 32'h0},
    '{fir_pkg::FUNC_SAMPLE, 6'd0,  32'h5555_5555, 1'b0, 32'h0}
  };

  fir_filter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .tap_index (tap_index),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < out_stall_pct);
  end

  function automatic bit fir_predict(input logic f, input logic [fir_pkg::INDEX_W-1:0] idx,
                                     input fir_pkg::word_t v, output fir_pkg::word_t sum);
    sum = '0;
    if (f == fir_pkg::FUNC_COEF) begin
      if (idx < fir_pkg::NUM_TAPS) tap_coef[idx[fir_pkg::TAP_W-1:0]] = v;
      return 1'b0;
    end
    for (int k = fir_pkg::NUM_TAPS - 1; k > 0; k--) sample_hist[k] = sample_hist[k-1];
    sample_hist[0] = v;
    for (int k = 0; k < fir_pkg::NUM_TAPS; k++) sum += tap_coef[k] * sample_hist[k];
    return 1'b1;
  endfunction

  function automatic fir_pkg::word_t pick_value();
    case ($urandom_range(7))
      0: pick_value = 32'h7FFF_FFFF;
      1: pick_value = 32'h8000_0000;
      2: pick_value = fir_pkg::word_t'($urandom_range(16)) - 32'd8;
      default: pick_value = $urandom();
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic f, input logic [fir_pkg::INDEX_W-1:0] idx,
                           input fir_pkg::word_t v,
                           input logic typed, input fir_pkg::word_t typed_sum);
    fir_pkg::word_t sum;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    tap_index <= idx;
    value     <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fir_predict(f, idx, v, sum)) begin
      expected_filtered.push_back(typed ? typed_sum : sum);
      samples_sent++;
    end else begin
      coef_writes++;
    end
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    int cycles;
    cycles = 0;
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_filtered.size() != 0 && cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      cycles++;
    end
    if (expected_filtered.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_filtered.size());
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_filtered
    fir_pkg::word_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_filtered.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, filtered);
        errors++;
      end else begin
        want = expected_filtered.pop_front();
        if (filtered !== want) begin
          $display("%0t: filtered mismatch, expected %h, got %h", $time, want, filtered);
          errors++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic                        f;
    logic [fir_pkg::INDEX_W-1:0] idx;
    int                          per_phase;
    foreach (tap_coef[k]) begin
      tap_coef[k] = '0;
      sample_hist[k] = '0;
    end
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[r])
      send_beat(directed[r].func, directed[r].tap_index, directed[r].value,
                directed[r].typed, directed[r].result);

    per_phase = RANDOM_ITEMS / PHASES;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 60; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 60; end
        default: begin in_idle_pct = 34; out_stall_pct = 34; end
      endcase
      for (int n = 0; n < per_phase; n++) begin
        if (phase == 2 && n == per_phase / 2) wait_results_drained();
        if ($urandom_range(3) == 0) begin
          f = fir_pkg::FUNC_COEF;
          idx = ($urandom_range(9) == 0)
              ? fir_pkg::INDEX_W'($urandom_range(63, fir_pkg::NUM_TAPS))
              : fir_pkg::INDEX_W'($urandom_range(fir_pkg::NUM_TAPS - 1));
        end else begin
          f = fir_pkg::FUNC_SAMPLE;
          idx = fir_pkg::INDEX_W'($urandom_range(63));
        end
        send_beat(f, idx, pick_value(), 1'b0, '0);
      end
    end

    wait_results_drained();
    repeat (fir_pkg::NUM_TAPS + 10) @(negedge clk);

    $display("Sent %0d samples and %0d coefficient writes; checked %0d results.",
             samples_sent, coef_writes, results_seen);
    $display("Covered tap extremes, out-of-range writes, wraparound and four idle mixes.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
